>>> src/oscdf_pkg.sv
// ----------------------------------------------------------------------------
// oscdf_pkg
// Shared types and constants for the OSC message deframer.
// ----------------------------------------------------------------------------
package oscdf_pkg;

   localparam int MAX_TYPE_TAGS     = 16;
   localparam int MAX_PATTERN_CHARS = 32;

   localparam int PATTERN_REGS   = 4;
   localparam int PATTERN_W      = 64;
   localparam int PATTERN_CHARS  = PATTERN_REGS * PATTERN_W / 8;
   localparam int CHAR_IDX_W     = $clog2(PATTERN_CHARS);
   localparam int PAT_LEN_W      = 6;
   localparam int CSR_INDEX_W    = 3;

   localparam int TAG_IDX_W      = (MAX_TYPE_TAGS > 1) ? $clog2(MAX_TYPE_TAGS) : 1;
   localparam int TAG_CNT_W      = $clog2(MAX_TYPE_TAGS + 1);
   localparam int ADDR_LEN_W     = 6;
   localparam int WORD_CNT_W     = 6;
   localparam int CMP_W          = 7;

   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 56;

   localparam logic [7:0] COMMA_CHAR = 8'd44;
   localparam logic [7:0] NULL_CHAR  = 8'd0;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_0_7   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_8_15  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_16_23 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_24_31 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN   = 3'd4;

   typedef enum logic [1:0] {
      PH_ADDRESS = 2'd0,
      PH_TYPES   = 2'd1,
      PH_PADDING = 2'd2,
      PH_DATA    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ADDRESS = 2'd0,
      KIND_WORD    = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_TAGS  = 2'd1,
      STATUS_PARTIAL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [PATTERN_REGS*PATTERN_W-1:0] pattern;   // char 0 in the top byte
      logic [PAT_LEN_W-1:0]              length;
   } cfg_type;

   typedef struct packed {
      kind_type              kind;
      logic                  matched;
      logic [31:0]           word;
      logic [WORD_CNT_W-1:0] index;
      logic [7:0]            tag;
      status_type            status;
      logic                  last;
   } rsp_type;

endpackage

>>> src/oscdf_csr.sv
// ----------------------------------------------------------------------------
// oscdf_csr
// Pattern and pattern length registers, written through a plain write port.
// ----------------------------------------------------------------------------
module oscdf_csr
   import oscdf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PATTERN_W-1:0]   csr_wdata,
   output cfg_type                cfg
);

   logic [PATTERN_W-1:0] pattern_ff [PATTERN_REGS];
   logic [PAT_LEN_W-1:0] length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_REGS; i++) begin
            pattern_ff[i] <= '0;
         end
         length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_0_7:   pattern_ff[0] <= csr_wdata;
            CSR_PATTERN_8_15:  pattern_ff[1] <= csr_wdata;
            CSR_PATTERN_16_23: pattern_ff[2] <= csr_wdata;
            CSR_PATTERN_24_31: pattern_ff[3] <= csr_wdata;
            CSR_PATTERN_LEN:   length_ff <= csr_wdata[PAT_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.pattern = {pattern_ff[0], pattern_ff[1], pattern_ff[2], pattern_ff[3]};
   assign cfg.length  = length_ff;

endmodule

>>> src/oscdf_parser.sv
// ----------------------------------------------------------------------------
// oscdf_parser
// Per-byte parse state, type tag store and result formation.
// ----------------------------------------------------------------------------
module oscdf_parser
   import oscdf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            accept,
   input  logic [7:0]      packet_byte,
   input  logic            end_of_packet,
   output logic            rsp_have,
   output rsp_type         rsp
);

   phase_type              phase_ff, phase_in;
   logic [ADDR_LEN_W-1:0]  addr_len_ff, addr_len_in;
   logic                   addr_ended_ff, addr_ended_in;
   logic                   mismatch_ff, mismatch_in;
   logic [1:0]             offset_ff, offset_in;
   logic [TAG_CNT_W-1:0]   tag_count_ff, tag_count_in;
   logic [23:0]            held_ff, held_in;
   logic [1:0]             byte_in_word_ff, byte_in_word_in;
   logic [WORD_CNT_W-1:0]  word_count_ff, word_count_in;
   logic                   wrapped_ff, wrapped_in;
   logic [7:0]             tag_store_ff [MAX_TYPE_TAGS];
   logic                   tag_write;
   logic [7:0]             pattern_char;
   logic [CHAR_IDX_W-1:0]  char_idx;

   assign char_idx     = addr_len_ff[CHAR_IDX_W-1:0];
   assign pattern_char = cfg.pattern[PATTERN_REGS*PATTERN_W-1 - 8*char_idx -: 8];

   always_comb begin
      phase_in        = phase_ff;
      addr_len_in     = addr_len_ff;
      addr_ended_in   = addr_ended_ff;
      mismatch_in     = mismatch_ff;
      offset_in       = offset_ff;
      tag_count_in    = tag_count_ff;
      held_in         = held_ff;
      byte_in_word_in = byte_in_word_ff;
      word_count_in   = word_count_ff;
      wrapped_in      = wrapped_ff;
      tag_write       = 1'b0;
      rsp_have        = 1'b0;
      rsp             = '0;

      case (phase_ff)
         PH_ADDRESS: begin
            if (packet_byte == COMMA_CHAR) begin
               rsp_have    = 1'b1;
               rsp.kind    = KIND_ADDRESS;
               rsp.matched = !mismatch_ff && (addr_len_ff == cfg.length);
               phase_in    = PH_TYPES;
               offset_in   = 2'd1;
            end else if (!addr_ended_ff) begin
               if (packet_byte == NULL_CHAR) begin
                  addr_ended_in = 1'b1;
               end else if (addr_len_ff >= ADDR_LEN_W'(MAX_PATTERN_CHARS)) begin
                  mismatch_in = 1'b1;
               end else begin
                  if (addr_len_ff >= cfg.length || pattern_char != packet_byte) begin
                     mismatch_in = 1'b1;
                  end
                  addr_len_in = addr_len_ff + 1'b1;
               end
            end
         end
         PH_TYPES: begin
            offset_in = offset_ff + 1'b1;
            if (packet_byte == NULL_CHAR) begin
               phase_in = (offset_in == 2'd0) ? PH_DATA : PH_PADDING;
            end else if (tag_count_ff < TAG_CNT_W'(MAX_TYPE_TAGS)) begin
               tag_write    = 1'b1;
               tag_count_in = tag_count_ff + 1'b1;
            end
         end
         PH_PADDING: begin
            offset_in = offset_ff + 1'b1;
            if (offset_in == 2'd0) begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (byte_in_word_ff == 2'd3) begin
               rsp_have  = 1'b1;
               rsp.kind  = KIND_WORD;
               rsp.word  = {held_ff, packet_byte};
               rsp.index = word_count_ff;
               if (!wrapped_ff && (CMP_W'(word_count_ff) < CMP_W'(tag_count_ff))) begin
                  rsp.tag = tag_store_ff[word_count_ff[TAG_IDX_W-1:0]];
               end
               word_count_in   = word_count_ff + 1'b1;
               wrapped_in      = wrapped_ff || (word_count_ff == '1);
               held_in         = '0;
               byte_in_word_in = 2'd0;
            end else begin
               held_in         = {held_ff[15:0], packet_byte};
               byte_in_word_in = byte_in_word_ff + 1'b1;
            end
         end
         default: ;
      endcase

      if (end_of_packet) begin
         if (phase_in == PH_ADDRESS || phase_in == PH_TYPES) begin
            rsp.status = STATUS_NO_TAGS;
         end else if (phase_in == PH_PADDING || byte_in_word_in != 2'd0) begin
            rsp.status = STATUS_PARTIAL;
         end else begin
            rsp.status = STATUS_OK;
         end
         if (!rsp_have) begin
            rsp.kind = KIND_END;
         end
         rsp_have        = 1'b1;
         rsp.last        = 1'b1;
         // drop all parse state for the next packet
         phase_in        = PH_ADDRESS;
         addr_len_in     = '0;
         addr_ended_in   = 1'b0;
         mismatch_in     = 1'b0;
         offset_in       = '0;
         tag_count_in    = '0;
         held_in         = '0;
         byte_in_word_in = '0;
         word_count_in   = '0;
         wrapped_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_ADDRESS;
         addr_len_ff     <= '0;
         addr_ended_ff   <= 1'b0;
         mismatch_ff     <= 1'b0;
         offset_ff       <= '0;
         tag_count_ff    <= '0;
         held_ff         <= '0;
         byte_in_word_ff <= '0;
         word_count_ff   <= '0;
         wrapped_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         addr_len_ff     <= addr_len_in;
         addr_ended_ff   <= addr_ended_in;
         mismatch_ff     <= mismatch_in;
         offset_ff       <= offset_in;
         tag_count_ff    <= tag_count_in;
         held_ff         <= held_in;
         byte_in_word_ff <= byte_in_word_in;
         word_count_ff   <= word_count_in;
         wrapped_ff      <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && tag_write) begin
         tag_store_ff[tag_count_ff[TAG_IDX_W-1:0]] <= packet_byte;
      end
   end

endmodule

>>> src/oscdf_rsp_buffer.sv
// ----------------------------------------------------------------------------
// oscdf_rsp_buffer
// Result register with a skid stage, so a stalled receiver costs no request.
// ----------------------------------------------------------------------------
module oscdf_rsp_buffer
   import oscdf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_valid_ff && !out_ready) begin
         // hold the head, park a new result in the skid stage
         if (push) begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end else if (skid_valid_ff) begin
         main_valid_in = 1'b1;
         main_in       = skid_ff;
         skid_valid_in = 1'b0;
      end else begin
         main_valid_in = push;
         main_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

>>> src/osc_message_deframer_core.sv
// ----------------------------------------------------------------------------
// osc_message_deframer_core
// OSC message deframer: address match, type tags and argument words.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one packet byte per request; req_tlast marks the final
//          byte of a packet.
//   rsp_*  carries results: an address match at the first comma, one
//          argument word per 4 data bytes (with index and type tag), and a
//          packet end status. The final byte's result has rsp_tlast set and
//          carries the end status, or is a separate end-status result.
//   csr_*  writes the pattern registers and the pattern length; write only
//          while the block is idle.
// Output: a result is registered in the result register, or parked in the
//   skid stage while the receiver stalls, before it shows on rsp_*.
// Throughput: one byte per cycle while the skid stage is empty; the parse
//   state takes a single pass of logic per byte; the result is registered.
// Stall: a result register plus a one-entry skid stage sit on the output;
//   req_tready drops only while the skid stage is occupied, so bytes that
//   give no result keep flowing while the receiver stalls, and the input
//   stops once a second result is waiting.
// Reset: parse state returns to the address phase, pattern registers clear,
//   output stages empty. The type tag store is not cleared.
// ----------------------------------------------------------------------------
module osc_message_deframer_core
   import oscdf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [7:0] packet_byte
   input  logic                   req_tlast,   // end_of_packet
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [0] address_matched,
                                               // [32:1] argument_word,
                                               // [38:33] argument_index,
                                               // [46:39] type_tag,
                                               // [48:47] end_status, rest 0
   output logic [1:0]             rsp_tuser,   // result_kind
   output logic                   rsp_tlast,   // last_of_packet
   // configuration write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PATTERN_W-1:0]   csr_wdata
);

   cfg_type cfg;
   logic    accept;
   logic    space;
   logic    rsp_have;
   rsp_type rsp_new;
   rsp_type rsp_head;

   // accept a byte whenever the skid stage has room
   assign req_tready = space;
   assign accept     = req_tvalid && space;

   oscdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   oscdf_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .accept        (accept),
      .packet_byte   (req_tdata[7:0]),
      .end_of_packet (req_tlast),
      .rsp_have      (rsp_have),
      .rsp           (rsp_new)
   );

   // push only results of accepted requests
   oscdf_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && rsp_have),
      .push_data (rsp_new),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_head)
   );

   assign rsp_tdata = {7'd0, rsp_head.status, rsp_head.tag, rsp_head.index,
                       rsp_head.word, rsp_head.matched};
   assign rsp_tuser = rsp_head.kind;
   assign rsp_tlast = rsp_head.last;

endmodule
